FILE: src/triangle_pixel_barycentric_shade_unit_assert.svh
// assertion macros for the triangle pixel shade unit
`ifndef TRIANGLE_PIXEL_BARYCENTRIC_SHADE_UNIT_ASSERT_SVH
`define TRIANGLE_PIXEL_BARYCENTRIC_SHADE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TPBS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define TPBS_ASSERT_NORST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define TPBS_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TPBS_ASSERT_NORST(lbl, clk_s, prop, msg)
`endif
`endif

FILE: src/tpbs_pkg.sv
// shared types, constants and field helpers of the triangle pixel shade unit
`default_nettype none
package tpbs_pkg;
  localparam int COORD_BITS       = 12;
  localparam int COLOR_BITS       = 24;
  localparam int CHAN_BITS        = 8;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int VERTEX_BITS      = 2 * COORD_BITS + COLOR_BITS;
  localparam int DIFF_BITS        = COORD_BITS + 1;
  localparam int PROD_BITS        = 2 * DIFF_BITS;
  localparam int EDGE_BITS        = 2 * COORD_BITS + 3;
  localparam int MAG_BITS         = 2 * COORD_BITS + 2;
  localparam int APB_DATA_BITS    = 64;
  localparam int APB_ADDR_BITS    = 5;
  localparam int REG_IDX_LSB      = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CHAN_BITS-1:0] chan_t;

  typedef enum logic [1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2
  } reg_idx_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
  } pixel_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    logic   winding;
  } pixel_out_t;

  function automatic coord_t vtx_x(input logic [VERTEX_BITS-1:0] v);
    return coord_t'(v[COLOR_BITS+COORD_BITS +: COORD_BITS]);
  endfunction

  function automatic coord_t vtx_y(input logic [VERTEX_BITS-1:0] v);
    return coord_t'(v[COLOR_BITS +: COORD_BITS]);
  endfunction

  // channel 0 red, 1 green, 2 blue
  function automatic chan_t vtx_chan(input logic [VERTEX_BITS-1:0] v, input int k);
    return v[(2-k)*CHAN_BITS +: CHAN_BITS];
  endfunction
endpackage
`default_nettype wire

FILE: src/tpbs_edge.sv
// edge products, coverage test and divider operand set-up (five stages)
`default_nettype none
module tpbs_edge #(
  parameter int WEIGHT_FRAC_BITS = tpbs_pkg::WEIGHT_FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire tpbs_pkg::pixel_in_t                   pixel,
  input  wire logic [tpbs_pkg::VERTEX_BITS-1:0]      vertex_a,
  input  wire logic [tpbs_pkg::VERTEX_BITS-1:0]      vertex_b,
  input  wire logic [tpbs_pkg::VERTEX_BITS-1:0]      vertex_c,
  output logic                                       out_valid,
  output tpbs_pkg::coord_t                           out_x,
  output tpbs_pkg::coord_t                           out_y,
  output logic                                       out_wind,
  output logic [tpbs_pkg::MAG_BITS-1:0]              den_mag,
  output logic [tpbs_pkg::MAG_BITS+WEIGHT_FRAC_BITS:0] num_v,
  output logic [tpbs_pkg::MAG_BITS+WEIGHT_FRAC_BITS:0] num_w
);
  import tpbs_pkg::*;

  localparam int NUM_BITS = MAG_BITS + WEIGHT_FRAC_BITS + 1;

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [EDGE_BITS-1:0] edge_t;

  function automatic logic [MAG_BITS-1:0] abs_mag(input edge_t v);
    edge_t n;
    n = v[EDGE_BITS-1] ? -v : v;
    return n[MAG_BITS-1:0];
  endfunction

  coord_t ax, ay, bx, by, cx, cy;
  assign ax = vtx_x(vertex_a);
  assign ay = vtx_y(vertex_a);
  assign bx = vtx_x(vertex_b);
  assign by = vtx_y(vertex_b);
  assign cx = vtx_x(vertex_c);
  assign cy = vtx_y(vertex_c);

  // stage 1: coordinate differences
  logic   s1_valid;
  coord_t s1_px, s1_py;
  diff_t  s1_ac_x, s1_ac_y, s1_pc_x, s1_pc_y;
  diff_t  s1_ba_x, s1_ba_y, s1_pa_x, s1_pa_y;
  diff_t  s1_cb_x, s1_cb_y, s1_pb_x, s1_pb_y;
  // stage 2: products
  logic   s2_valid;
  coord_t s2_px, s2_py;
  prod_t  s2_m0, s2_m1, s2_m2, s2_m3, s2_m4, s2_m5;
  // stage 3: edge products
  logic   s3_valid;
  coord_t s3_px, s3_py;
  edge_t  s3_d1, s3_d2, s3_d3;
  // stage 4: coverage, denominator, magnitudes
  logic   s4_valid, s4_wind;
  coord_t s4_px, s4_py;
  edge_t  s4_den;
  logic [MAG_BITS-1:0] s4_av, s4_aw;
  logic   cov_neg, cov_pos;
  logic [MAG_BITS-1:0] den_abs;

  assign cov_neg = (s3_d1 < 0) && (s3_d2 < 0) && (s3_d3 < 0);
  assign cov_pos = (s3_d1 > 0) && (s3_d2 > 0) && (s3_d3 > 0);
  assign den_abs = abs_mag(s4_den);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid && (cov_neg || cov_pos);
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px   <= pixel.pixel_x;
      s1_py   <= pixel.pixel_y;
      s1_ac_x <= DIFF_BITS'(ax) - DIFF_BITS'(cx);
      s1_ac_y <= DIFF_BITS'(ay) - DIFF_BITS'(cy);
      s1_pc_x <= DIFF_BITS'(pixel.pixel_x) - DIFF_BITS'(cx);
      s1_pc_y <= DIFF_BITS'(pixel.pixel_y) - DIFF_BITS'(cy);
      s1_ba_x <= DIFF_BITS'(bx) - DIFF_BITS'(ax);
      s1_ba_y <= DIFF_BITS'(by) - DIFF_BITS'(ay);
      s1_pa_x <= DIFF_BITS'(pixel.pixel_x) - DIFF_BITS'(ax);
      s1_pa_y <= DIFF_BITS'(pixel.pixel_y) - DIFF_BITS'(ay);
      s1_cb_x <= DIFF_BITS'(cx) - DIFF_BITS'(bx);
      s1_cb_y <= DIFF_BITS'(cy) - DIFF_BITS'(by);
      s1_pb_x <= DIFF_BITS'(pixel.pixel_x) - DIFF_BITS'(bx);
      s1_pb_y <= DIFF_BITS'(pixel.pixel_y) - DIFF_BITS'(by);

      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_m0 <= PROD_BITS'(s1_ac_x) * PROD_BITS'(s1_pc_y);
      s2_m1 <= PROD_BITS'(s1_ac_y) * PROD_BITS'(s1_pc_x);
      s2_m2 <= PROD_BITS'(s1_ba_x) * PROD_BITS'(s1_pa_y);
      s2_m3 <= PROD_BITS'(s1_ba_y) * PROD_BITS'(s1_pa_x);
      s2_m4 <= PROD_BITS'(s1_cb_x) * PROD_BITS'(s1_pb_y);
      s2_m5 <= PROD_BITS'(s1_cb_y) * PROD_BITS'(s1_pb_x);

      s3_px <= s2_px;
      s3_py <= s2_py;
      s3_d1 <= EDGE_BITS'(s2_m0) - EDGE_BITS'(s2_m1);
      s3_d2 <= EDGE_BITS'(s2_m2) - EDGE_BITS'(s2_m3);
      s3_d3 <= EDGE_BITS'(s2_m4) - EDGE_BITS'(s2_m5);

      // d1 is the b weight numerator, d2 the c weight numerator, sum the area
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_wind <= cov_pos;
      s4_den  <= s3_d1 + s3_d2 + s3_d3;
      s4_av   <= abs_mag(s3_d1);
      s4_aw   <= abs_mag(s3_d2);

      // dividend carries half the divisor for round to nearest
      out_x    <= s4_px;
      out_y    <= s4_py;
      out_wind <= s4_wind;
      den_mag  <= den_abs;
      num_v    <= NUM_BITS'({s4_av, {WEIGHT_FRAC_BITS{1'b0}}}) + NUM_BITS'(den_abs >> 1);
      num_w    <= NUM_BITS'({s4_aw, {WEIGHT_FRAC_BITS{1'b0}}}) + NUM_BITS'(den_abs >> 1);
    end
  end
endmodule
`default_nettype wire

FILE: src/tpbs_div_step.sv
// one registered restoring-division step for both weights
`default_nettype none
module tpbs_div_step #(
  parameter int MAG_W = tpbs_pkg::MAG_BITS,
  parameter int Q_W   = tpbs_pkg::WEIGHT_FRAC_BITS + 1,
  parameter int PAY_W = 2 * tpbs_pkg::COORD_BITS + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [MAG_W-1:0] in_d,
  input  wire logic [PAY_W-1:0] in_pay,
  input  wire logic [MAG_W-1:0] in_r_v,
  input  wire logic [Q_W-1:0]   in_lo_v,
  input  wire logic [Q_W-1:0]   in_q_v,
  input  wire logic [MAG_W-1:0] in_r_w,
  input  wire logic [Q_W-1:0]   in_lo_w,
  input  wire logic [Q_W-1:0]   in_q_w,
  output logic                  out_valid,
  output logic [MAG_W-1:0]      out_d,
  output logic [PAY_W-1:0]      out_pay,
  output logic [MAG_W-1:0]      out_r_v,
  output logic [Q_W-1:0]        out_lo_v,
  output logic [Q_W-1:0]        out_q_v,
  output logic [MAG_W-1:0]      out_r_w,
  output logic [Q_W-1:0]        out_lo_w,
  output logic [Q_W-1:0]        out_q_w
);
  logic [MAG_W:0] t_v, t_w, dx;
  logic           ge_v, ge_w;
  logic [MAG_W:0] sub_v, sub_w;

  assign dx    = {1'b0, in_d};
  assign t_v   = {in_r_v, in_lo_v[Q_W-1]};
  assign t_w   = {in_r_w, in_lo_w[Q_W-1]};
  assign ge_v  = t_v >= dx;
  assign ge_w  = t_w >= dx;
  assign sub_v = t_v - dx;
  assign sub_w = t_w - dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d    <= in_d;
      out_pay  <= in_pay;
      out_r_v  <= ge_v ? sub_v[MAG_W-1:0] : t_v[MAG_W-1:0];
      out_r_w  <= ge_w ? sub_w[MAG_W-1:0] : t_w[MAG_W-1:0];
      out_lo_v <= in_lo_v << 1;
      out_lo_w <= in_lo_w << 1;
      out_q_v  <= {in_q_v[Q_W-2:0], ge_v};
      out_q_w  <= {in_q_w[Q_W-2:0], ge_w};
    end
  end
endmodule
`default_nettype wire

FILE: src/tpbs_shade.sv
// colour interpolation, rounding and clamping (three stages, last is the output register)
`default_nettype none
module tpbs_shade #(
  parameter int WEIGHT_FRAC_BITS = tpbs_pkg::WEIGHT_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [WEIGHT_FRAC_BITS:0]        vq,
  input  wire logic [WEIGHT_FRAC_BITS:0]        wq,
  input  wire tpbs_pkg::coord_t                 in_x,
  input  wire tpbs_pkg::coord_t                 in_y,
  input  wire logic                             in_wind,
  input  wire logic [tpbs_pkg::VERTEX_BITS-1:0] vertex_a,
  input  wire logic [tpbs_pkg::VERTEX_BITS-1:0] vertex_b,
  input  wire logic [tpbs_pkg::VERTEX_BITS-1:0] vertex_c,
  output logic                                  out_valid,
  output tpbs_pkg::pixel_out_t                  out_data
);
  import tpbs_pkg::*;

  localparam int WW = WEIGHT_FRAC_BITS + 2;
  localparam int PW = WEIGHT_FRAC_BITS + 11;
  localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] CHAN_MAX = PW'(255);

  typedef logic signed [WW-1:0] wgt_t;
  typedef logic signed [PW-1:0] acc_t;

  function automatic chan_t clamp_chan(input acc_t s);
    acc_t t;
    t = s >>> WEIGHT_FRAC_BITS;
    if (s < 0) begin
      return '0;
    end else if (t > CHAN_MAX) begin
      return '1;
    end
    return t[CHAN_BITS-1:0];
  endfunction

  // stage a: third weight
  logic   a_valid, a_wind;
  coord_t a_x, a_y;
  wgt_t   a_uq, a_vq, a_wq;
  // stage b: weighted channels
  logic   b_valid, b_wind;
  coord_t b_x, b_y;
  acc_t   b_pu [3];
  acc_t   b_pv [3];
  acc_t   b_pw [3];
  acc_t   sum  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = b_pu[k] + b_pv[k] + b_pw[k] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= in_x;
      a_y    <= in_y;
      a_wind <= in_wind;
      a_uq   <= ONE - WW'(vq) - WW'(wq);
      a_vq   <= WW'(vq);
      a_wq   <= WW'(wq);

      b_x    <= a_x;
      b_y    <= a_y;
      b_wind <= a_wind;
      for (int k = 0; k < 3; k++) begin
        b_pu[k] <= PW'(a_uq) * PW'($signed({1'b0, vtx_chan(vertex_a, k)}));
        b_pv[k] <= PW'(a_vq) * PW'($signed({1'b0, vtx_chan(vertex_b, k)}));
        b_pw[k] <= PW'(a_wq) * PW'($signed({1'b0, vtx_chan(vertex_c, k)}));
      end

      out_data.out_x   <= b_x;
      out_data.out_y   <= b_y;
      out_data.red     <= clamp_chan(sum[0]);
      out_data.green   <= clamp_chan(sum[1]);
      out_data.blue    <= clamp_chan(sum[2]);
      out_data.winding <= b_wind;
    end
  end
endmodule
`default_nettype wire

FILE: src/triangle_pixel_barycentric_shade_unit.sv
// top level of the triangle pixel barycentric shade unit
// usage:
//   the triangle sits in three apb registers, vertex_a at 0x00, vertex_b at 0x08 and
//   vertex_c at 0x10, each 48 bits: x in 47:36, y in 35:24 (signed), rgb in 23:0
//   registers must be written only while the pipe is empty; the block does not enforce
//   this; pready is always high. pixel requests arrive on in_valid/in_ready/in_data; a
//   covered pixel leaves as one request on out_valid/out_ready/out_data, an uncovered
//   or edge pixel leaves nothing. the pipe is five stages of edge maths, one stage per
//   quotient bit in the weight divider, then three stages of shading
//   throughput is one pixel per clock unless the output stalls; the bit-per-stage
//   divider sets the depth, the single 13x13 multiply per product sets the stage length
//   the whole pipe advances together: when a result sits unclaimed in the output
//   register, in_ready drops and every stage holds, so nothing is lost or repeated
//   bubbles and rejected pixels travel as cleared valid bits
//   reset clears all valid bits and the three vertex registers
`default_nettype none
`include "triangle_pixel_barycentric_shade_unit_assert.svh"
module triangle_pixel_barycentric_shade_unit #(
  parameter int WEIGHT_FRAC_BITS = tpbs_pkg::WEIGHT_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // pixel requests in
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire tpbs_pkg::pixel_in_t                  in_data,
  // shaded pixels out
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output tpbs_pkg::pixel_out_t                      out_data,
  // register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tpbs_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [tpbs_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [tpbs_pkg::APB_DATA_BITS-1:0]        prdata,
  output logic                                      pready
);
  import tpbs_pkg::*;

  localparam int Q_W   = WEIGHT_FRAC_BITS + 1;
  localparam int NUM_W = MAG_BITS + Q_W;
  localparam int PAY_W = 2 * COORD_BITS + 1;

  // vertex registers
  logic [VERTEX_BITS-1:0] vertex_a, vertex_b, vertex_c;
  reg_idx_t               reg_idx;
  logic                   pwr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:REG_IDX_LSB]);
  assign pwr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= '0;
      vertex_b <= '0;
      vertex_c <= '0;
    end else if (pwr) begin
      case (reg_idx)
        REG_VERTEX_A: vertex_a <= pwdata[VERTEX_BITS-1:0];
        REG_VERTEX_B: vertex_b <= pwdata[VERTEX_BITS-1:0];
        REG_VERTEX_C: vertex_c <= pwdata[VERTEX_BITS-1:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VERTEX_A: prdata = APB_DATA_BITS'(vertex_a);
      REG_VERTEX_B: prdata = APB_DATA_BITS'(vertex_b);
      REG_VERTEX_C: prdata = APB_DATA_BITS'(vertex_c);
      default:      prdata = '0;
    endcase
  end

  // single pipe enable: advance unless the output register is held
  logic pipe_en;
  assign pipe_en  = !out_valid || out_ready;
  assign in_ready = pipe_en;

  // edge maths and coverage
  logic                 e_valid, e_wind;
  coord_t               e_x, e_y;
  logic [MAG_BITS-1:0]  e_den;
  logic [NUM_W-1:0]     e_num_v, e_num_w;

  tpbs_edge #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_edge (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_valid (in_valid),
    .pixel    (in_data),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .out_valid(e_valid),
    .out_x    (e_x),
    .out_y    (e_y),
    .out_wind (e_wind),
    .den_mag  (e_den),
    .num_v    (e_num_v),
    .num_w    (e_num_w)
  );

  // weight divider, one quotient bit per stage; the quotient never reaches 2^Q_W
  logic                dv_valid [Q_W+1];
  logic [MAG_BITS-1:0] dv_d     [Q_W+1];
  logic [PAY_W-1:0]    dv_pay   [Q_W+1];
  logic [MAG_BITS-1:0] dv_r_v   [Q_W+1];
  logic [Q_W-1:0]      dv_lo_v  [Q_W+1];
  logic [Q_W-1:0]      dv_q_v   [Q_W+1];
  logic [MAG_BITS-1:0] dv_r_w   [Q_W+1];
  logic [Q_W-1:0]      dv_lo_w  [Q_W+1];
  logic [Q_W-1:0]      dv_q_w   [Q_W+1];

  assign dv_valid[0] = e_valid;
  assign dv_d[0]     = e_den;
  assign dv_pay[0]   = {e_x, e_y, e_wind};
  assign dv_r_v[0]   = e_num_v[NUM_W-1:Q_W];
  assign dv_lo_v[0]  = e_num_v[Q_W-1:0];
  assign dv_q_v[0]   = '0;
  assign dv_r_w[0]   = e_num_w[NUM_W-1:Q_W];
  assign dv_lo_w[0]  = e_num_w[Q_W-1:0];
  assign dv_q_w[0]   = '0;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    tpbs_div_step #(
      .MAG_W(MAG_BITS),
      .Q_W  (Q_W),
      .PAY_W(PAY_W)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (pipe_en),
      .in_valid (dv_valid[i]),
      .in_d     (dv_d[i]),
      .in_pay   (dv_pay[i]),
      .in_r_v   (dv_r_v[i]),
      .in_lo_v  (dv_lo_v[i]),
      .in_q_v   (dv_q_v[i]),
      .in_r_w   (dv_r_w[i]),
      .in_lo_w  (dv_lo_w[i]),
      .in_q_w   (dv_q_w[i]),
      .out_valid(dv_valid[i+1]),
      .out_d    (dv_d[i+1]),
      .out_pay  (dv_pay[i+1]),
      .out_r_v  (dv_r_v[i+1]),
      .out_lo_v (dv_lo_v[i+1]),
      .out_q_v  (dv_q_v[i+1]),
      .out_r_w  (dv_r_w[i+1]),
      .out_lo_w (dv_lo_w[i+1]),
      .out_q_w  (dv_q_w[i+1])
    );
  end

  // shading and output register
  logic   dq_wind;
  coord_t dq_x, dq_y;
  assign {dq_x, dq_y, dq_wind} = dv_pay[Q_W];

  tpbs_shade #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_shade (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_valid (dv_valid[Q_W]),
    .vq       (dv_q_v[Q_W]),
    .wq       (dv_q_w[Q_W]),
    .in_x     (dq_x),
    .in_y     (dq_y),
    .in_wind  (dq_wind),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // checks
  logic [Q_W:0] weight_sum;
  logic [Q_W:0] weight_lim;
  assign weight_sum = {1'b0, dv_q_v[Q_W]} + {1'b0, dv_q_w[Q_W]};
  assign weight_lim = (Q_W+1)'(1) << WEIGHT_FRAC_BITS;

  `TPBS_ASSERT_NORST(a_reset_empties_output, clk, rst |=> !out_valid, "output valid after reset")
  `TPBS_ASSERT(a_weight_sum_bound, clk, rst, dv_valid[Q_W] |-> (weight_sum <= weight_lim + 1'b1), "weights exceed one")
  `TPBS_ASSERT(a_stall_holds_divider, clk, rst, !pipe_en |=> $stable(dv_valid[Q_W]), "divider moved in stall")
endmodule
`default_nettype wire
